/* rtl/core/rv64i_integer_execute_assert.svh */
// assertion macros shared by the execute unit
`ifndef RV64I_INTEGER_EXECUTE_ASSERT_SVH
`define RV64I_INTEGER_EXECUTE_ASSERT_SVH
`define RVX_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RVX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* rtl/core/rvx_pkg.sv */
// ----------------------------------------------------------------------------
// rvx_pkg
// shared constants, operation codes and result type of the execute unit
// ----------------------------------------------------------------------------
package rvx_pkg;
  localparam int unsigned XLEN          = 64;
  localparam int unsigned REG_COUNT_DEF = 32;

  localparam logic [5:0] OP_LUI = 6'd0, OP_AUIPC = 6'd1, OP_JAL = 6'd2, OP_JALR = 6'd3;
  localparam logic [5:0] OP_BEQ = 6'd4, OP_BNE = 6'd5, OP_BLT = 6'd6, OP_BGE = 6'd7;
  localparam logic [5:0] OP_BLTU = 6'd8, OP_BGEU = 6'd9;
  localparam logic [5:0] OP_LB = 6'd10, OP_LWU = 6'd16;
  localparam logic [5:0] OP_SB = 6'd17, OP_SD = 6'd20;
  localparam logic [5:0] OP_ADDI = 6'd21, OP_SLTI = 6'd22, OP_SLTIU = 6'd23;
  localparam logic [5:0] OP_XORI = 6'd24, OP_ORI = 6'd25, OP_ANDI = 6'd26;
  localparam logic [5:0] OP_SLLI = 6'd27, OP_SRLI = 6'd28, OP_SRAI = 6'd29;
  localparam logic [5:0] OP_ADD = 6'd30, OP_SUB = 6'd31, OP_SLL = 6'd32, OP_SLT = 6'd33;
  localparam logic [5:0] OP_SLTU = 6'd34, OP_XOR = 6'd35, OP_SRL = 6'd36, OP_SRA = 6'd37;
  localparam logic [5:0] OP_OR = 6'd38, OP_AND = 6'd39, OP_ADDIW = 6'd40;
  localparam logic [5:0] OP_SLLIW = 6'd41, OP_SRLIW = 6'd42, OP_SRAIW = 6'd43;
  localparam logic [5:0] OP_ADDW = 6'd44, OP_SUBW = 6'd45, OP_SLLW = 6'd46;
  localparam logic [5:0] OP_SRLW = 6'd47, OP_SRAW = 6'd48;
  localparam logic [5:0] OP_ECALL = 6'd50, OP_EBREAK = 6'd51;

  localparam logic [1:0] REQ_NONE = 2'd0, REQ_LOAD = 2'd1, REQ_STORE = 2'd2;

  localparam logic [2:0] CAUSE_NONE = 3'd0, CAUSE_IMIS = 3'd1, CAUSE_LMIS = 3'd2;
  localparam logic [2:0] CAUSE_SMIS = 3'd3, CAUSE_ECALL = 3'd4, CAUSE_BRK = 3'd5;

  typedef struct packed {
    logic        rd_written;
    logic [4:0]  rd_number;
    logic [63:0] rd_value;
    logic [63:0] next_pc;
    logic [1:0]  mem_request;
    logic [63:0] mem_address;
    logic [1:0]  mem_size_log2;
    logic [63:0] store_data;
    logic [2:0]  trap_cause;
    logic        retired;
  } rvx_result_t;

  // register file write port
  typedef struct packed {
    logic        en;
    logic [4:0]  addr;
    logic [63:0] data;
  } rvx_wr_t;

  function automatic logic [63:0] rvx_sext32(input logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic logic [63:0] rvx_wmask(input logic [1:0] lg);
    case (lg)
      2'd0:    return 64'h0000_0000_0000_00ff;
      2'd1:    return 64'h0000_0000_0000_ffff;
      2'd2:    return 64'h0000_0000_ffff_ffff;
      default: return '1;
    endcase
  endfunction
endpackage

/* rtl/core/rvx_ram.sv */
// ----------------------------------------------------------------------------
// rvx_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rvx_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/rvx_regfile.sv */
// ----------------------------------------------------------------------------
// rvx_regfile
// register file in two ram copies with valid bits and write forwarding
// ----------------------------------------------------------------------------
module rvx_regfile import rvx_pkg::*; #(
  parameter int unsigned REG_COUNT = REG_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        rd_en,
  input  logic [4:0]  rs1,
  input  logic [4:0]  rs2,
  input  rvx_wr_t     wr,
  output logic [63:0] rs1_val,
  output logic [63:0] rs2_val
);
  localparam int unsigned AW = $clog2(REG_COUNT);

  logic [REG_COUNT-1:0] vld_r, vld_nxt;
  logic [63:0] q1, q2;
  logic [4:0]  rs1_r, rs2_r;
  logic        fw1_r, fw2_r;
  logic [63:0] fwd_r;
  logic        wr_ok;
  logic [AW-1:0] ra1, ra2;

  assign wr_ok = wr.en && (wr.addr != 5'd0) && ({27'd0, wr.addr} < REG_COUNT);

  // while the stage holds, keep reading the held addresses
  assign ra1 = rd_en ? rs1[AW-1:0] : rs1_r[AW-1:0];
  assign ra2 = rd_en ? rs2[AW-1:0] : rs2_r[AW-1:0];

  rvx_ram #(.WIDTH(64), .DEPTH(REG_COUNT)) u_ram1 (
    .clk(clk), .we(wr_ok), .waddr(wr.addr[AW-1:0]), .wdata(wr.data),
    .raddr(ra1), .rdata(q1));
  rvx_ram #(.WIDTH(64), .DEPTH(REG_COUNT)) u_ram2 (
    .clk(clk), .we(wr_ok), .waddr(wr.addr[AW-1:0]), .wdata(wr.data),
    .raddr(ra2), .rdata(q2));

  always_comb begin
    vld_nxt = vld_r;
    if (wr_ok) begin
      vld_nxt[wr.addr[AW-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (rd_en) begin
      rs1_r <= rs1;
      rs2_r <= rs2;
      fw1_r <= wr_ok && wr.addr == rs1;
      fw2_r <= wr_ok && wr.addr == rs2;
      fwd_r <= wr.data;
    end
  end

  // same-cycle write is forwarded past the ram
  always_comb begin
    if (rs1_r == 5'd0 || {27'd0, rs1_r} >= REG_COUNT) rs1_val = '0;
    else if (fw1_r) rs1_val = fwd_r;
    else if (!vld_r[rs1_r[AW-1:0]]) rs1_val = '0;
    else rs1_val = q1;
    if (rs2_r == 5'd0 || {27'd0, rs2_r} >= REG_COUNT) rs2_val = '0;
    else if (fw2_r) rs2_val = fwd_r;
    else if (!vld_r[rs2_r[AW-1:0]]) rs2_val = '0;
    else rs2_val = q2;
  end
endmodule

/* rtl/core/rvx_alu.sv */
// ----------------------------------------------------------------------------
// rvx_alu
// combinational execute of one decoded instruction or load return
// ----------------------------------------------------------------------------
module rvx_alu import rvx_pkg::*; #(
  parameter int unsigned REG_COUNT = REG_COUNT_DEF
) (
  input  logic        action,
  input  logic [5:0]  operation,
  input  logic [4:0]  dest_index,
  input  logic [31:0] immediate,
  input  logic [63:0] load_data,
  input  logic [63:0] lhs,
  input  logic [63:0] rhs,
  input  logic [63:0] pc,
  input  logic        pl_valid,
  input  logic [4:0]  pl_dest,
  input  logic [2:0]  pl_kind,
  output rvx_result_t res,
  output logic        pl_set,
  output logic        pl_clr
);
  logic [63:0] imm, val, addr, t, sum, ld;
  logic        wr, taken, br;
  logic [2:0]  cause, k;
  logic [1:0]  lg, sz;
  logic [5:0]  sh;
  logic [4:0]  rd;

  always_comb begin
    imm   = {{32{immediate[31]}}, immediate};
    wr    = 1'b0;
    val   = '0;
    cause = CAUSE_NONE;
    br    = 1'b0;
    taken = 1'b0;
    addr  = '0;
    lg    = 2'd0;
    t     = '0;
    sum   = lhs + imm;
    sh    = imm[5:0];
    rd    = dest_index;
    pl_set = 1'b0;
    pl_clr = 1'b0;
    k     = 3'd0;
    sz    = 2'd0;
    ld    = '0;
    res   = '0;
    res.next_pc = pc + 64'd4;
    if (action) begin
      res.next_pc = pc;
      if (pl_valid) begin
        sz = (pl_kind < 3'd4) ? pl_kind[1:0] : 2'(pl_kind - 3'd4);
        ld = load_data & rvx_wmask(sz);
        if (pl_kind < 3'd3) begin
          case (sz)
            2'd0:    ld = {{56{ld[7]}}, ld[7:0]};
            2'd1:    ld = {{48{ld[15]}}, ld[15:0]};
            default: ld = {{32{ld[31]}}, ld[31:0]};
          endcase
        end
        rd = pl_dest;
        wr = 1'b1;
        val = ld;
        pl_clr = 1'b1;
      end
    end else begin
      res.retired = 1'b1;
      case (operation)
        OP_LUI:   begin wr = 1'b1; val = imm; end
        OP_AUIPC: begin wr = 1'b1; val = pc + imm; end
        OP_JAL, OP_JALR: begin
          t = (operation == OP_JAL) ? pc + imm : {sum[63:1], 1'b0};
          if (t[1:0] != 2'd0) cause = CAUSE_IMIS;
          else begin wr = 1'b1; val = pc + 64'd4; res.next_pc = t; end
        end
        OP_BEQ:  begin br = 1'b1; taken = lhs == rhs; end
        OP_BNE:  begin br = 1'b1; taken = lhs != rhs; end
        OP_BLT:  begin br = 1'b1; taken = $signed(lhs) < $signed(rhs); end
        OP_BGE:  begin br = 1'b1; taken = !($signed(lhs) < $signed(rhs)); end
        OP_BLTU: begin br = 1'b1; taken = lhs < rhs; end
        OP_BGEU: begin br = 1'b1; taken = lhs >= rhs; end
        OP_ADDI:  begin wr = 1'b1; val = sum; end
        OP_SLTI:  begin wr = 1'b1; val = {63'd0, $signed(lhs) < $signed(imm)}; end
        OP_SLTIU: begin wr = 1'b1; val = {63'd0, lhs < imm}; end
        OP_XORI:  begin wr = 1'b1; val = lhs ^ imm; end
        OP_ORI:   begin wr = 1'b1; val = lhs | imm; end
        OP_ANDI:  begin wr = 1'b1; val = lhs & imm; end
        OP_SLLI:  begin wr = 1'b1; val = lhs << sh; end
        OP_SRLI:  begin wr = 1'b1; val = lhs >> sh; end
        OP_SRAI:  begin wr = 1'b1; val = 64'($signed(lhs) >>> sh); end
        OP_ADD:   begin wr = 1'b1; val = lhs + rhs; end
        OP_SUB:   begin wr = 1'b1; val = lhs - rhs; end
        OP_SLL:   begin wr = 1'b1; val = lhs << rhs[5:0]; end
        OP_SLT:   begin wr = 1'b1; val = {63'd0, $signed(lhs) < $signed(rhs)}; end
        OP_SLTU:  begin wr = 1'b1; val = {63'd0, lhs < rhs}; end
        OP_XOR:   begin wr = 1'b1; val = lhs ^ rhs; end
        OP_SRL:   begin wr = 1'b1; val = lhs >> rhs[5:0]; end
        OP_SRA:   begin wr = 1'b1; val = 64'($signed(lhs) >>> rhs[5:0]); end
        OP_OR:    begin wr = 1'b1; val = lhs | rhs; end
        OP_AND:   begin wr = 1'b1; val = lhs & rhs; end
        OP_ADDIW: begin wr = 1'b1; val = rvx_sext32(sum); end
        OP_SLLIW: begin wr = 1'b1; val = rvx_sext32({32'd0, lhs[31:0] << sh[4:0]}); end
        OP_SRLIW: begin wr = 1'b1; val = rvx_sext32({32'd0, lhs[31:0] >> sh[4:0]}); end
        OP_SRAIW: begin
          wr = 1'b1; val = rvx_sext32({32'd0, 32'($signed(lhs[31:0]) >>> sh[4:0])});
        end
        OP_ADDW:  begin wr = 1'b1; val = rvx_sext32(lhs + rhs); end
        OP_SUBW:  begin wr = 1'b1; val = rvx_sext32(lhs - rhs); end
        OP_SLLW:  begin wr = 1'b1; val = rvx_sext32({32'd0, lhs[31:0] << rhs[4:0]}); end
        OP_SRLW:  begin wr = 1'b1; val = rvx_sext32({32'd0, lhs[31:0] >> rhs[4:0]}); end
        OP_SRAW:  begin
          wr = 1'b1; val = rvx_sext32({32'd0, 32'($signed(lhs[31:0]) >>> rhs[4:0])});
        end
        OP_ECALL:  cause = CAUSE_ECALL;
        OP_EBREAK: cause = CAUSE_BRK;
        default: begin
          if (operation >= OP_LB && operation <= OP_LWU) begin
            k = 3'(operation - OP_LB);
            lg = (k < 3'd4) ? k[1:0] : 2'(k - 3'd4);
            addr = sum;
            if ((addr[2:0] & 3'((4'd1 << lg) - 4'd1)) != 3'd0) begin
              cause = CAUSE_LMIS;
            end else begin
              res.mem_request = REQ_LOAD;
              pl_set = 1'b1;
            end
          end else if (operation >= OP_SB && operation <= OP_SD) begin
            lg = 2'(operation - OP_SB);
            addr = sum;
            if ((addr[2:0] & 3'((4'd1 << lg) - 4'd1)) != 3'd0) begin
              cause = CAUSE_SMIS;
            end else begin
              res.mem_request = REQ_STORE;
              res.store_data = rhs & rvx_wmask(lg);
            end
          end
        end
      endcase
      if (br && taken) begin
        t = pc + imm;
        if (t[1:0] != 2'd0) cause = CAUSE_IMIS;
        else res.next_pc = t;
      end
      if (cause != CAUSE_NONE) begin
        wr = 1'b0;
        res.next_pc = pc;
        res.retired = 1'b0;
      end
    end
    if (wr && rd != 5'd0 && {27'd0, rd} < REG_COUNT) begin
      res.rd_written = 1'b1;
      res.rd_number = rd;
      res.rd_value = val;
    end
    res.mem_address = addr;
    res.mem_size_log2 = lg;
    res.trap_cause = cause;
  end
endmodule

/* rtl/core/rv64i_integer_execute.sv */
// ----------------------------------------------------------------------------
// rv64i_integer_execute
// rv64i execute unit: ram register file, pc, one pending load
// ----------------------------------------------------------------------------
// in_ channel carries one decoded instruction (in_tuser = 0) or returning load
// data (in_tuser = 1) per request; out_ channel gives one result per request.
// cfg_ writes the entry pc straight into the pc; write only while idle.
// each request is taken into a stage register while the register file ram
// reads rs1/rs2, executed from the stage register and written back as the
// result register loads: out_tvalid rises after the stage and result
// registers, one request per cycle sustained while out_tready stays high.
// a write-back in the same cycle as a read of that register is forwarded.
// pc and pending load live in flops updated at execute, so back-to-back
// requests always see the previous result.
// if out_tready is low with a result held, the result register holds and
// the pipeline stalls; in_tready drops only when both stages are full.
// after reset the registers read zero (per-entry valid bits), pc is zero,
// and no load is pending.
// ----------------------------------------------------------------------------
`include "rv64i_integer_execute_assert.svh"
module rv64i_integer_execute import rvx_pkg::*; #(
  parameter int unsigned REG_COUNT = REG_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [63:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // operation, dest_index, src1_index, src2_index, immediate, load_data, pad
  input  logic [119:0] in_tdata,
  // action
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // rd_written, rd_number, rd_value, next_pc, mem_request, mem_address,
  // mem_size_log2, store_data, trap_cause, retired, pad
  output logic [279:0] out_tdata
);
  logic         s1_v_r;
  logic         s1_act_r;
  logic [119:0] s1_d_r;
  logic         o_v_r;
  rvx_result_t  o_r, res;
  logic [63:0]  pc_r, lhs, rhs;
  logic         pl_v_r, pl_set, pl_clr;
  logic [4:0]   pl_dest_r;
  logic [2:0]   pl_kind_r;
  logic         adv, s1_go;
  rvx_wr_t      wr;

  assign s1_go = s1_v_r && (!o_v_r || out_tready);
  assign adv = !s1_v_r || s1_go;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  assign wr.en = s1_go && res.rd_written;
  assign wr.addr = res.rd_number;
  assign wr.data = res.rd_value;

  rvx_regfile #(.REG_COUNT(REG_COUNT)) u_rf (
    .clk(clk), .rst_n(rst_n), .rd_en(adv),
    .rs1(in_tdata[15:11]), .rs2(in_tdata[20:16]), .wr(wr),
    .rs1_val(lhs), .rs2_val(rhs));

  rvx_alu #(.REG_COUNT(REG_COUNT)) u_alu (
    .action(s1_act_r), .operation(s1_d_r[5:0]), .dest_index(s1_d_r[10:6]),
    .immediate(s1_d_r[52:21]), .load_data(s1_d_r[116:53]),
    .lhs(lhs), .rhs(rhs), .pc(pc_r),
    .pl_valid(pl_v_r), .pl_dest(pl_dest_r), .pl_kind(pl_kind_r),
    .res(res), .pl_set(pl_set), .pl_clr(pl_clr));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      o_v_r  <= 1'b0;
      pc_r   <= '0;
      pl_v_r <= 1'b0;
      pl_dest_r <= '0;
      pl_kind_r <= '0;
    end else begin
      if (adv) begin
        s1_v_r <= in_tvalid;
      end
      if (s1_go) begin
        o_v_r <= 1'b1;
        pc_r  <= res.next_pc;
        if (pl_set) begin
          pl_v_r <= (s1_d_r[10:6] != 5'd0) && ({27'd0, s1_d_r[10:6]} < REG_COUNT);
          pl_dest_r <= s1_d_r[10:6];
          pl_kind_r <= 3'(s1_d_r[5:0] - OP_LB);
        end else if (pl_clr) begin
          pl_v_r <= 1'b0;
        end
      end else if (out_tready) begin
        o_v_r <= 1'b0;
      end
      if (cfg_valid) begin
        pc_r <= cfg_data;
      end
    end
    if (adv) begin
      s1_act_r <= in_tuser;
      s1_d_r   <= in_tdata;
    end
    if (s1_go) begin
      o_r <= res;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata = {10'd0, o_r.retired, o_r.trap_cause, o_r.store_data,
                      o_r.mem_size_log2, o_r.mem_address, o_r.mem_request,
                      o_r.next_pc, o_r.rd_value, o_r.rd_number, o_r.rd_written};

  `RVX_ASSERT(a_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result lost")
  `RVX_ASSERT(a_trap_nowr, clk, rst_n, s1_go && res.trap_cause != CAUSE_NONE |-> !wr.en, "trap wrote rd")
  `RVX_ASSERT(a_wr_nz, clk, rst_n, wr.en |-> wr.addr != 5'd0, "x0 written")
  `RVX_ASSERT(a_ret, clk, rst_n, s1_go && res.retired |-> res.trap_cause == CAUSE_NONE, "retired with trap")
endmodule
